>>> rtl/msb_pkg.sv
// package for the multi-stack shared buffer: sizes, pointer widths,
// status codes and the command bundle from controller to datapath
// no dependencies
`default_nettype none

package msb_pkg;

    localparam int NUM_STACKS = 8;
    localparam int CAPACITY   = 64;

    // slot index and pointer widths; a pointer also holds the null value CAPACITY
    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PTR_W  = $clog2(CAPACITY + 1);
    localparam int STK_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

    localparam int MODE_W   = 1;
    localparam int SID_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(CAPACITY);

    localparam logic [MODE_W-1:0] MODE_PUSH = 1'b0;
    localparam logic [MODE_W-1:0] MODE_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic accept;  // latch the request and issue the store reads
        logic exec;    // apply pointer updates and load the result register
    } cmd_t;

endpackage

`default_nettype wire

>>> rtl/msb_ctrl.sv
// controller for the multi-stack shared buffer: two-state sequencer
// and the result-valid flag; depends on msb_pkg
`default_nettype none

module msb_ctrl (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output msb_pkg::cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    // a waiting result that leaves on this edge frees the result register in time
    assign s_tready   = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign cmd.accept = s_tvalid && s_tready;
    assign cmd.exec   = (state_reg == ST_EXEC);
    assign m_tvalid   = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.exec) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_exec_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |-> !out_valid_reg)
        else $error("result register busy while executing");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> (state_reg == ST_EXEC) && !s_tready)
        else $error("accepted transfer not followed by execute");
`endif

endmodule

`default_nettype wire

>>> rtl/msb_datapath.sv
// datapath for the multi-stack shared buffer: slot data and link stores,
// stack tops, free-list head, fill count and result register; depends on msb_pkg
`default_nettype none

module msb_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire msb_pkg::cmd_t                  cmd,
    input  wire logic [msb_pkg::MODE_W-1:0]     mode,
    input  wire logic [msb_pkg::SID_W-1:0]      stack_id,
    input  wire logic [msb_pkg::VALUE_W-1:0]    push_value,
    output logic      [msb_pkg::STATUS_W-1:0]   status,
    output logic      [msb_pkg::VALUE_W-1:0]    pop_value
);

    localparam int PTR_W  = msb_pkg::PTR_W;
    localparam int SLOT_W = msb_pkg::SLOT_W;
    localparam int STK_W  = msb_pkg::STK_W;

    logic [msb_pkg::VALUE_W-1:0] data_mem [msb_pkg::CAPACITY];
    logic [PTR_W-1:0]            link_mem [msb_pkg::CAPACITY];

    logic [PTR_W-1:0] top_reg [msb_pkg::NUM_STACKS];
    logic [PTR_W-1:0] free_head_reg;
    // slots below the fill count have had their link written; at or above it the
    // link store read is replaced by the reset chain value slot + 1
    logic [PTR_W-1:0] fill_reg;

    logic [msb_pkg::MODE_W-1:0]  mode_reg;
    logic                        ok_reg;
    logic                        written_reg;
    logic [SLOT_W-1:0]           slot_reg;
    logic [STK_W-1:0]            sid_reg;
    logic [PTR_W-1:0]            old_top_reg;
    logic [msb_pkg::VALUE_W-1:0] val_reg;
    logic [PTR_W-1:0]            link_rd_reg;
    logic [msb_pkg::VALUE_W-1:0] data_rd_reg;
    logic [msb_pkg::STATUS_W-1:0] status_reg;
    logic [msb_pkg::VALUE_W-1:0] pop_value_reg;

    logic             sid_ok;
    logic [STK_W-1:0] sid_idx;
    logic [PTR_W-1:0] top_cur;
    logic [PTR_W-1:0] sel_ptr;
    logic             ptr_ok;
    logic [SLOT_W-1:0] slot;
    logic [PTR_W-1:0] link_val;
    logic             do_push;
    logic             do_pop;

    assign sid_ok  = 32'(stack_id) < msb_pkg::NUM_STACKS;
    assign sid_idx = STK_W'(stack_id);
    assign top_cur = sid_ok ? top_reg[sid_idx] : msb_pkg::NULL_PTR;
    assign sel_ptr = (mode == msb_pkg::MODE_POP) ? top_cur : free_head_reg;
    assign ptr_ok  = sel_ptr < msb_pkg::NULL_PTR;
    assign slot    = SLOT_W'(sel_ptr);

    assign link_val = written_reg ? link_rd_reg : (PTR_W'(slot_reg) + PTR_W'(1));
    assign do_push  = cmd.exec && ok_reg && (mode_reg == msb_pkg::MODE_PUSH);
    assign do_pop   = cmd.exec && ok_reg && (mode_reg == msb_pkg::MODE_POP);

    // request latch and synchronous store reads
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mode_reg    <= mode;
            ok_reg      <= sid_ok && ptr_ok;
            written_reg <= sel_ptr < fill_reg;
            slot_reg    <= slot;
            sid_reg     <= sid_idx;
            old_top_reg <= top_cur;
            val_reg     <= push_value;
            link_rd_reg <= link_mem[slot];
            data_rd_reg <= data_mem[slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            data_mem[slot_reg] <= val_reg;
            link_mem[slot_reg] <= old_top_reg;
        end else if (do_pop) begin
            link_mem[slot_reg] <= free_head_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < msb_pkg::NUM_STACKS; i++) begin
                top_reg[i] <= msb_pkg::NULL_PTR;
            end
            free_head_reg <= '0;
            fill_reg      <= '0;
        end else if (do_push) begin
            top_reg[sid_reg] <= PTR_W'(slot_reg);
            free_head_reg    <= link_val;
            if (PTR_W'(slot_reg) == fill_reg) begin
                fill_reg <= fill_reg + PTR_W'(1);
            end
        end else if (do_pop) begin
            top_reg[sid_reg] <= link_val;
            free_head_reg    <= PTR_W'(slot_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            if (ok_reg) begin
                status_reg <= msb_pkg::STATUS_DONE;
            end else if (mode_reg == msb_pkg::MODE_POP) begin
                status_reg <= msb_pkg::STATUS_EMPTY;
            end else begin
                status_reg <= msb_pkg::STATUS_FULL;
            end
            pop_value_reg <= do_pop ? data_rd_reg : '0;
        end
    end

    assign status    = status_reg;
    assign pop_value = pop_value_reg;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= msb_pkg::NULL_PTR)
        else $error("fill count beyond capacity");

    a_free_head_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        free_head_reg <= msb_pkg::NULL_PTR)
        else $error("free-list head corrupt");

    a_pop_frees_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        do_pop |=> free_head_reg == PTR_W'($past(slot_reg)))
        else $error("popped slot not returned to free list");

    a_push_takes_head: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && (mode == msb_pkg::MODE_PUSH) && sid_ok && ptr_ok
        |=> slot_reg == SLOT_W'($past(free_head_reg)))
        else $error("push does not take the free-list head");
`endif

endmodule

`default_nettype wire

>>> rtl/multi_stack_shared_buffer.sv
// top level of the multi-stack shared buffer: stream ports, controller
// and datapath; depends on msb_pkg, msb_ctrl, msb_datapath
//
//   channel   direction   tdata                               tuser
//   s_        in          [2:0] stack_id, [34:3] push_value   [0] mode
//   m_        out         [31:0] pop_value                    [1:0] status
//
// each operation runs through an accept step and an execute step: the accept
// cycle reads the stack top from flops and issues the link and data reads from
// the synchronous slot stores, and the execute state that follows applies the
// pointer updates and loads the result register; a new transfer is taken only
// once the previous operation has executed and while the result side keeps up
// a stalled result holds the block after its current operation finishes
// the link store needs no clearing pass, a fill count stands in for its reset chain
`default_nettype none

module multi_stack_shared_buffer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [2:0] stack_id, [34:3] push_value, rest zero
    input  wire logic [0:0]  s_tuser,   // [0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] pop_value
    output logic [1:0]       m_tuser    // [1:0] status
);

    msb_pkg::cmd_t cmd;

    msb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    msb_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .mode       (s_tuser[0]),
        .stack_id   (s_tdata[2:0]),
        .push_value (s_tdata[34:3]),
        .status     (m_tuser),
        .pop_value  (m_tdata)
    );

endmodule

`default_nettype wire
